@@ hw/rtl/rbtq_pkg.sv @@
`default_nettype none

package rbtq_pkg;

    // default sizing
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    // fixed field widths of the stream payload
    localparam int REQ_BITS         = 3;
    localparam int TID_BITS         = 8;
    localparam int COUNT_BITS       = 5;
    localparam int IN_TDATA_BITS    = 16;
    localparam int OUT_TDATA_BITS   = 24;

    // request kinds
    localparam logic [REQ_BITS-1:0] REQ_ADD       = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_YIELD     = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_RESUME    = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_TERMINATE = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_BLOCK     = 3'd4;

    // per-cell and per-row control: load beats shift
    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/rbtq_cell.sv @@
`default_nettype none

module rbtq_cell
    import rbtq_pkg::*;
#(
    parameter int W = DEF_ID_BITS
)
(
    input  wire logic        clk,
    input  wire chain_ctrl_t ctrl,
    input  wire logic [W-1:0] din,
    input  wire logic [W-1:0] nbr,
    output logic      [W-1:0] q
);

    logic [W-1:0] q_reg;
    logic [W-1:0] q_next;

    // load from the shared bus, else take the neighbor toward the tail
    always_comb
    begin
        q_next = q_reg;
        if (ctrl.load)
        begin
            q_next = din;
        end
        else if (ctrl.shift)
        begin
            q_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rbtq_chain.sv @@
`default_nettype none

module rbtq_chain
    import rbtq_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    parameter int W     = DEF_ID_BITS,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire chain_ctrl_t      ctrl,
    input  wire logic [CNT_W-1:0] pos,
    input  wire logic [W-1:0]     din,
    output logic      [W-1:0]     head
);

    logic [W-1:0] cell_q [DEPTH];

    // row of cells, index 0 is the queue head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        chain_ctrl_t  cell_ctrl;
        logic [W-1:0] cell_nbr;

        assign cell_ctrl.load  = ctrl.load && (pos == CNT_W'(i));
        assign cell_ctrl.shift = ctrl.shift;

        if (i == DEPTH - 1)
        begin : g_last
            assign cell_nbr = '0;
        end
        else
        begin : g_mid
            assign cell_nbr = cell_q[i+1];
        end

        rbtq_cell #(
            .W (W)
        ) u_cell (
            .clk  (clk),
            .ctrl (cell_ctrl),
            .din  (din),
            .nbr  (cell_nbr),
            .q    (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

`default_nettype wire

@@ hw/rtl/ready_block_thread_queues.sv @@
// channel  | direction | tdata (low bit first)                    | tuser
// s_axis   | in        | thread_id[7:0], disk_ready[8]            | req_type[2:0]
// m_axis   | out       | dispatch_valid[0], dispatch_id[8:1],     | -
//          |           | removed_any[9], overflow[10],            |
//          |           | ready_count[15:11], blocked_count[20:16] |
//
// add, yield, block and unknown kinds finish when accepted; resume first pushes, then releases
// terminate visits every ready entry once: the ready row rotates once through itself
// one request is in flight at a time; s_axis_tready stays low until the result is taken
// a stalled m_axis holds its result and blocks the next request
// after reset both queues are empty; queue cells need no clearing

`default_nettype none

module ready_block_thread_queues
    import rbtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // thread_id, disk_ready
    input  wire logic [REQ_BITS-1:0]       s_axis_tuser,   // req_type
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [OUT_TDATA_BITS-1:0] m_axis_tdata    // dispatch_valid, dispatch_id,
                                                           // removed_any, overflow,
                                                           // ready_count, blocked_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PAD_W = OUT_TDATA_BITS - 3 - TID_BITS - 2 * COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RESUME = 3'b010,
        ST_TERM   = 3'b100
    } state_t;

    state_t                      state_reg,     state_next;
    logic [CNT_W-1:0]            rfill_reg,     rfill_next;
    logic [CNT_W-1:0]            bfill_reg,     bfill_next;
    logic [CNT_W-1:0]            term_left_reg, term_left_next;
    logic [ID_BITS-1:0]          id_reg,        id_next;
    logic                        disk_reg,      disk_next;
    logic                        ovf_reg,       ovf_next;
    logic                        rm_reg,        rm_next;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_TDATA_BITS-1:0]   out_data_reg,  out_data_next;

    chain_ctrl_t        rctrl, bctrl;
    logic [CNT_W-1:0]   rpos, bpos;
    logic [ID_BITS-1:0] rdin, bdin, rhead, bhead;

    logic                in_accept;
    logic [REQ_BITS-1:0] req;
    logic [ID_BITS-1:0]  id_in;
    logic                disk_in;

    logic               finish;
    logic               res_dv, res_rm, res_ovf;
    logic [ID_BITS-1:0] res_did;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign req           = s_axis_tuser;
    assign id_in         = ID_BITS'(s_axis_tdata[TID_BITS-1:0]);
    assign disk_in       = s_axis_tdata[TID_BITS];

    // ready queue row
    rbtq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .W     (ID_BITS),
        .CNT_W (CNT_W)
    ) u_ready (
        .clk  (clk),
        .ctrl (rctrl),
        .pos  (rpos),
        .din  (rdin),
        .head (rhead)
    );

    // blocked queue row
    rbtq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .W     (ID_BITS),
        .CNT_W (CNT_W)
    ) u_blocked (
        .clk  (clk),
        .ctrl (bctrl),
        .pos  (bpos),
        .din  (bdin),
        .head (bhead)
    );

    // request sequencer
    always_comb
    begin
        state_next     = state_reg;
        rfill_next     = rfill_reg;
        bfill_next     = bfill_reg;
        term_left_next = term_left_reg;
        id_next        = id_reg;
        disk_next      = disk_reg;
        ovf_next       = ovf_reg;
        rm_next        = rm_reg;
        rctrl          = '0;
        bctrl          = '0;
        rpos           = rfill_reg;
        bpos           = bfill_reg;
        rdin           = id_in;
        bdin           = id_in;
        finish         = 1'b0;
        res_dv         = 1'b0;
        res_did        = '0;
        res_rm         = 1'b0;
        res_ovf        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (req)
                        REQ_ADD:
                        begin
                            if (rfill_reg < CNT_W'(QUEUE_DEPTH))
                            begin
                                rctrl.load = 1'b1;
                                rfill_next = rfill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_ovf = 1'b1;
                            end
                            finish = 1'b1;
                        end
                        REQ_YIELD:
                        begin
                            if (rfill_reg != '0)
                            begin
                                rctrl.shift = 1'b1;
                                res_dv      = 1'b1;
                                res_did     = rhead;
                                rfill_next  = rfill_reg - CNT_W'(1);
                            end
                            finish = 1'b1;
                        end
                        REQ_BLOCK:
                        begin
                            if (bfill_reg < CNT_W'(QUEUE_DEPTH))
                            begin
                                bctrl.load = 1'b1;
                                bfill_next = bfill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_ovf = 1'b1;
                            end
                            finish = 1'b1;
                        end
                        REQ_RESUME:
                        begin
                            ovf_next = 1'b0;
                            if (rfill_reg < CNT_W'(QUEUE_DEPTH))
                            begin
                                rctrl.load = 1'b1;
                                rfill_next = rfill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            disk_next  = disk_in;
                            state_next = ST_RESUME;
                        end
                        REQ_TERMINATE:
                        begin
                            id_next = id_in;
                            rm_next = 1'b0;
                            if (rfill_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                term_left_next = rfill_reg;
                                state_next     = ST_TERM;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_RESUME:
            begin
                // release the blocked head into the ready queue if disk_ready was set and it fits
                res_ovf = ovf_reg;
                rdin    = bhead;
                if ((bfill_reg != '0) && disk_reg)
                begin
                    if (rfill_reg < CNT_W'(QUEUE_DEPTH))
                    begin
                        rctrl.load  = 1'b1;
                        bctrl.shift = 1'b1;
                        rfill_next  = rfill_reg + CNT_W'(1);
                        bfill_next  = bfill_reg - CNT_W'(1);
                    end
                    else
                    begin
                        res_ovf = 1'b1;
                    end
                end
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TERM:
            begin
                // pop the head and append it at the tail unless it matches
                rdin        = rhead;
                rpos        = rfill_reg - CNT_W'(1);
                rctrl.shift = 1'b1;
                res_rm      = rm_reg;
                if (rhead != id_reg)
                begin
                    rctrl.load = 1'b1;
                end
                else
                begin
                    rfill_next = rfill_reg - CNT_W'(1);
                    rm_next    = 1'b1;
                    res_rm     = 1'b1;
                end
                term_left_next = term_left_reg - CNT_W'(1);
                if (term_left_reg == CNT_W'(1))
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{PAD_W{1'b0}},
                              COUNT_BITS'(bfill_next),
                              COUNT_BITS'(rfill_next),
                              res_ovf,
                              res_rm,
                              TID_BITS'(res_did),
                              res_dv};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rfill_reg     <= '0;
            bfill_reg     <= '0;
            term_left_reg <= '0;
            disk_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            rm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rfill_reg     <= rfill_next;
            bfill_reg     <= bfill_next;
            term_left_reg <= term_left_next;
            disk_reg      <= disk_next;
            ovf_reg       <= ovf_next;
            rm_reg        <= rm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // fill counts never pass the queue depth
    a_rfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rfill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ready fill above depth");

    a_bfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bfill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("blocked fill above depth");

    // a terminate walk never grows the ready queue
    a_term_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TERM) |=> (rfill_reg <= $past(rfill_reg)))
        else $error("ready fill grew during terminate");

    // a yield on a non-empty queue pops one entry and reports at once
    a_yield_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req == REQ_YIELD) && (rfill_reg != '0))
        |=> (m_axis_tvalid && m_axis_tdata[0] &&
             (rfill_reg == $past(rfill_reg) - CNT_W'(1))))
        else $error("yield did not pop the ready head");

    // while a request is in flight no result is pending
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !m_axis_tvalid)
        else $error("result pending during multi-cycle request");

endmodule

`default_nettype wire
